// File: hdl/rwl_pkg.sv
// Shared types and constants for the reader/writer lock arbiter.
package rwl_pkg;

    localparam int unsigned ID_W = 4;
    localparam int unsigned RC_W = 5;
    localparam int unsigned READER_MAX = 31;
    localparam int unsigned RESULT_LIMIT = 16;
    localparam int unsigned WAKE_W = 4;

    typedef enum logic [1:0] {
        CMD_START_READ  = 2'd0,
        CMD_END_READ    = 2'd1,
        CMD_START_WRITE = 2'd2,
        CMD_END_WRITE   = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        SEL_ITEM = 2'd0,
        SEL_RQ   = 2'd1,
        SEL_WQ   = 2'd2
    } id_sel_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_WAKE = 2'd2
    } state_t;

    typedef struct packed {
        logic [1:0]      command;
        logic [ID_W-1:0] requester_id;
    } request_t;

    typedef struct packed {
        logic [ID_W-1:0] grant_id;
        logic [1:0]      grant_kind;
        logic            last_flag;
    } result_t;

    typedef struct packed {
        logic    load;
        logic    rc_inc;
        logic    rc_dec;
        logic    wr_set;
        logic    wr_clr;
        logic    rq_push;
        logic    rq_pop;
        logic    wq_push;
        logic    wq_pop;
        logic    wake_clr;
        logic    wake_inc;
        logic    emit;
        kind_t   kind;
        id_sel_t id_sel;
        logic    last;
    } dp_cmd_t;

    typedef struct packed {
        command_t command;
        logic     id_bad;
        logic     rc_zero;
        logic     rc_one;
        logic     rc_max;
        logic     rc_near_max;
        logic     wr_act;
        logic     rq_empty;
        logic     rq_full;
        logic     rq_one;
        logic     wq_empty;
        logic     wq_full;
        logic     wake_at_limit;
    } dp_stat_t;

endpackage

// File: hdl/rwl_queue.sv
// Circular FIFO of requester numbers with a registered read of the head entry.
module rwl_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic                     pop,
    input  logic [rwl_pkg::ID_W-1:0] wdata,
    output logic [rwl_pkg::ID_W-1:0] rdata,
    output logic                     empty,
    output logic                     full,
    output logic                     one
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [rwl_pkg::ID_W-1:0] mem [DEPTH];
    logic [rwl_pkg::ID_W-1:0] rdata_reg;
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic do_push;
    logic do_pop;

    assign empty = (count_reg == '0);
    assign full = (count_reg == CNT_W'(DEPTH));
    assign one = (count_reg == CNT_W'(1));
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign rdata = rdata_reg;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        count_next = count_reg;
        if (do_pop)
        begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
        end
        if (do_push)
        begin
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[tail_reg] <= wdata;
        end
        rdata_reg <= mem[head_next];
    end

endmodule

// File: hdl/rwl_datapath.sv
// Lock state, wait queues, item capture and result register.
module rwl_datapath #(
    parameter int unsigned MAX_REQUESTERS = 16,
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rwl_pkg::request_t  request,
    input  rwl_pkg::dp_cmd_t   cmd,
    output rwl_pkg::dp_stat_t  stat,
    output rwl_pkg::result_t   result,
    output logic               result_strobe
);

    rwl_pkg::request_t item_reg;
    rwl_pkg::result_t  result_reg;
    rwl_pkg::result_t  result_next;
    logic strobe_reg;
    logic [rwl_pkg::RC_W-1:0] rc_reg;
    logic [rwl_pkg::RC_W-1:0] rc_next;
    logic wr_reg;
    logic wr_next;
    logic [rwl_pkg::WAKE_W-1:0] wake_reg;
    logic [rwl_pkg::WAKE_W-1:0] wake_next;
    logic [rwl_pkg::ID_W-1:0] rq_head;
    logic [rwl_pkg::ID_W-1:0] wq_head;
    logic rq_empty;
    logic rq_full;
    logic rq_one;
    logic wq_empty;
    logic wq_full;
    logic wq_one;

    rwl_queue #(.DEPTH(QUEUE_DEPTH)) u_rq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd.rq_push),
        .pop   (cmd.rq_pop),
        .wdata (item_reg.requester_id),
        .rdata (rq_head),
        .empty (rq_empty),
        .full  (rq_full),
        .one   (rq_one)
    );

    rwl_queue #(.DEPTH(QUEUE_DEPTH)) u_wq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd.wq_push),
        .pop   (cmd.wq_pop),
        .wdata (item_reg.requester_id),
        .rdata (wq_head),
        .empty (wq_empty),
        .full  (wq_full),
        .one   (wq_one)
    );

    always_comb
    begin
        stat.command = rwl_pkg::command_t'(item_reg.command);
        stat.id_bad = (32'(item_reg.requester_id) >= 32'(MAX_REQUESTERS));
        stat.rc_zero = (rc_reg == '0);
        stat.rc_one = (rc_reg == rwl_pkg::RC_W'(1));
        stat.rc_max = (rc_reg == rwl_pkg::RC_W'(rwl_pkg::READER_MAX));
        stat.rc_near_max = (rc_reg == rwl_pkg::RC_W'(rwl_pkg::READER_MAX - 1));
        stat.wr_act = wr_reg;
        stat.rq_empty = rq_empty;
        stat.rq_full = rq_full;
        stat.rq_one = rq_one;
        stat.wq_empty = wq_empty;
        stat.wq_full = wq_full || (wq_one && 1'b0);
        stat.wake_at_limit = (wake_reg == rwl_pkg::WAKE_W'(rwl_pkg::RESULT_LIMIT - 1));
    end

    always_comb
    begin
        rc_next = rc_reg;
        if (cmd.rc_inc)
        begin
            rc_next = rc_reg + rwl_pkg::RC_W'(1);
        end
        else if (cmd.rc_dec)
        begin
            rc_next = rc_reg - rwl_pkg::RC_W'(1);
        end
        wr_next = wr_reg;
        if (cmd.wr_set)
        begin
            wr_next = 1'b1;
        end
        else if (cmd.wr_clr)
        begin
            wr_next = 1'b0;
        end
        wake_next = wake_reg;
        if (cmd.wake_clr)
        begin
            wake_next = '0;
        end
        else if (cmd.wake_inc)
        begin
            wake_next = wake_reg + rwl_pkg::WAKE_W'(1);
        end
    end

    always_comb
    begin
        result_next = result_reg;
        case (cmd.id_sel)
            rwl_pkg::SEL_RQ: result_next.grant_id = rq_head;
            rwl_pkg::SEL_WQ: result_next.grant_id = wq_head;
            default:         result_next.grant_id = item_reg.requester_id;
        endcase
        result_next.grant_kind = cmd.kind;
        result_next.last_flag = cmd.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_reg <= '0;
            wr_reg <= 1'b0;
            wake_reg <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            rc_reg <= rc_next;
            wr_reg <= wr_next;
            wake_reg <= wake_next;
            strobe_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= request;
        end
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;
    assign result_strobe = strobe_reg;

endmodule

// File: hdl/rwl_ctrl.sv
// Controller state machine that sequences one item through the datapath.
module rwl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rwl_pkg::dp_stat_t stat,
    output rwl_pkg::dp_cmd_t  cmd,
    output logic              busy
);

    rwl_pkg::state_t state_reg;
    rwl_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rwl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rwl_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = rwl_pkg::ST_EXEC;
                end
            end
            rwl_pkg::ST_EXEC:
            begin
                state_next = rwl_pkg::ST_IDLE;
                if (!stat.id_bad && stat.command == rwl_pkg::CMD_END_WRITE && stat.wr_act
                    && !stat.rq_empty)
                begin
                    state_next = rwl_pkg::ST_WAKE;
                end
            end
            rwl_pkg::ST_WAKE:
            begin
                if (stat.rq_one || stat.wake_at_limit || stat.rc_near_max)
                begin
                    state_next = rwl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rwl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.kind = rwl_pkg::KIND_ERROR;
        cmd.id_sel = rwl_pkg::SEL_ITEM;
        busy = (state_reg != rwl_pkg::ST_IDLE);
        case (state_reg)
            rwl_pkg::ST_IDLE:
            begin
                cmd.load = start;
            end
            rwl_pkg::ST_EXEC:
            begin
                cmd.last = 1'b1;
                if (stat.id_bad)
                begin
                    cmd.emit = 1'b1;
                end
                else
                begin
                    case (stat.command)
                        rwl_pkg::CMD_START_READ:
                        begin
                            if (stat.wr_act)
                            begin
                                cmd.rq_push = !stat.rq_full;
                                cmd.emit = stat.rq_full;
                            end
                            else if (stat.rc_max)
                            begin
                                cmd.emit = 1'b1;
                            end
                            else
                            begin
                                cmd.rc_inc = 1'b1;
                                cmd.emit = 1'b1;
                                cmd.kind = rwl_pkg::KIND_READ;
                            end
                        end
                        rwl_pkg::CMD_END_READ:
                        begin
                            if (stat.rc_zero)
                            begin
                                cmd.emit = 1'b1;
                            end
                            else
                            begin
                                cmd.rc_dec = 1'b1;
                                if (stat.rc_one && !stat.wr_act && !stat.wq_empty)
                                begin
                                    cmd.wr_set = 1'b1;
                                    cmd.wq_pop = 1'b1;
                                    cmd.emit = 1'b1;
                                    cmd.kind = rwl_pkg::KIND_WRITE;
                                    cmd.id_sel = rwl_pkg::SEL_WQ;
                                end
                            end
                        end
                        rwl_pkg::CMD_START_WRITE:
                        begin
                            if (!stat.rc_zero || stat.wr_act)
                            begin
                                cmd.wq_push = !stat.wq_full;
                                cmd.emit = stat.wq_full;
                            end
                            else
                            begin
                                cmd.wr_set = 1'b1;
                                cmd.emit = 1'b1;
                                cmd.kind = rwl_pkg::KIND_WRITE;
                            end
                        end
                        rwl_pkg::CMD_END_WRITE:
                        begin
                            if (!stat.wr_act)
                            begin
                                cmd.emit = 1'b1;
                            end
                            else if (!stat.rq_empty)
                            begin
                                cmd.wr_clr = 1'b1;
                                cmd.wake_clr = 1'b1;
                            end
                            else if (!stat.wq_empty)
                            begin
                                cmd.wq_pop = 1'b1;
                                cmd.emit = 1'b1;
                                cmd.kind = rwl_pkg::KIND_WRITE;
                                cmd.id_sel = rwl_pkg::SEL_WQ;
                            end
                            else
                            begin
                                cmd.wr_clr = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd.emit = 1'b1;
                        end
                    endcase
                end
            end
            rwl_pkg::ST_WAKE:
            begin
                cmd.rc_inc = 1'b1;
                cmd.rq_pop = 1'b1;
                cmd.wake_inc = 1'b1;
                cmd.emit = 1'b1;
                cmd.kind = rwl_pkg::KIND_READ;
                cmd.id_sel = rwl_pkg::SEL_RQ;
                cmd.last = stat.rq_one || stat.wake_at_limit || stat.rc_near_max;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: hdl/reader_writer_lock_arbiter_core.sv
// Top level of the reader/writer lock arbiter.
//
// Channel   Ports                   Accepted when
// request   start, request, busy    start high and busy low at a rising edge
// result    result_strobe, result   result_strobe high; shown for one cycle
//
// An item is accepted while idle; the exec state then decides it and loads any result.
// An end write that wakes readers adds a wake state with one queue pop per woken reader.
// Reset clears the lock state and empties both wait queues at once.
// Busy stays high until the last result of an item is loaded; results cannot be stalled.
module reader_writer_lock_arbiter_core #(
    parameter int unsigned MAX_REQUESTERS = 16,
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rwl_pkg::request_t request,
    output logic              busy,
    output logic              result_strobe,
    output rwl_pkg::result_t  result
);

    rwl_pkg::dp_cmd_t  dp_cmd;
    rwl_pkg::dp_stat_t dp_stat;

    rwl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (dp_stat),
        .cmd   (dp_cmd),
        .busy  (busy)
    );

    rwl_datapath #(
        .MAX_REQUESTERS (MAX_REQUESTERS),
        .QUEUE_DEPTH    (QUEUE_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .request       (request),
        .cmd           (dp_cmd),
        .stat          (dp_stat),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule

// File: verif/reader_writer_lock_arbiter_core_tb.sv
// Self-checking testbench for the reader/writer lock arbiter core with its own grant predictor.
module reader_writer_lock_arbiter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REQUESTERS = 16;
    localparam int QUEUE_DEPTH = 16;
    localparam int CLK_PERIOD = 10;
    localparam int RANDOM_ITEMS = 330;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PREDICTED = -1;

    typedef struct {
        rwl_pkg::command_t        cmd;
        logic [rwl_pkg::ID_W-1:0] id;
        int                       grants;
        logic [rwl_pkg::ID_W-1:0] grant_id;
        rwl_pkg::kind_t           grant_kind;
    } directed_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    rwl_pkg::request_t request;
    logic              busy;
    logic              result_strobe;
    rwl_pkg::result_t  result;

    int unsigned              lock_readers;
    bit                       lock_writer;
    logic [rwl_pkg::ID_W-1:0] waiting_readers[$];
    logic [rwl_pkg::ID_W-1:0] waiting_writers[$];
    rwl_pkg::result_t         step_grants[$];
    rwl_pkg::result_t         expected_grants[$];
    directed_row_t            directed_rows[$];

    bit                       typed_row;
    bit                       typed_grant;
    logic [rwl_pkg::ID_W-1:0] typed_id;
    rwl_pkg::kind_t           typed_kind;

    int burst_left;
    int sent_count;
    int grants_seen;
    int error_grants;
    int error_count;
    int queue_full_drops;
    int reader_limit_drops;
    int widest_wakeup;

    reader_writer_lock_arbiter_core #(
        .MAX_REQUESTERS(MAX_REQUESTERS),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .request(request),
        .busy(busy),
        .result_strobe(result_strobe),
        .result(result)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void add_grant(logic [rwl_pkg::ID_W-1:0] id, rwl_pkg::kind_t kind);
        rwl_pkg::result_t g;
        g.grant_id = id;
        g.grant_kind = kind;
        g.last_flag = 1'b0;
        step_grants.push_back(g);
    endfunction

    function automatic void apply_lock_request(rwl_pkg::request_t req);
        logic [rwl_pkg::ID_W-1:0] id;
        id = req.requester_id;
        step_grants.delete();
        if (int'(id) >= MAX_REQUESTERS)
        begin
            add_grant(id, rwl_pkg::KIND_ERROR);
        end
        else
        begin
            case (rwl_pkg::command_t'(req.command))
                rwl_pkg::CMD_START_READ:
                    if (lock_writer)
                    begin
                        if (waiting_readers.size() >= QUEUE_DEPTH)
                        begin
                            queue_full_drops++;
                            add_grant(id, rwl_pkg::KIND_ERROR);
                        end
                        else
                        begin
                            waiting_readers.push_back(id);
                        end
                    end
                    else if (lock_readers >= rwl_pkg::READER_MAX)
                    begin
                        reader_limit_drops++;
                        add_grant(id, rwl_pkg::KIND_ERROR);
                    end
                    else
                    begin
                        lock_readers++;
                        add_grant(id, rwl_pkg::KIND_READ);
                    end
                rwl_pkg::CMD_END_READ:
                    if (lock_readers == 0)
                    begin
                        add_grant(id, rwl_pkg::KIND_ERROR);
                    end
                    else
                    begin
                        lock_readers--;
                        if (lock_readers == 0 && !lock_writer && waiting_writers.size() != 0)
                        begin
                            lock_writer = 1'b1;
                            add_grant(waiting_writers.pop_front(), rwl_pkg::KIND_WRITE);
                        end
                    end
                rwl_pkg::CMD_START_WRITE:
                    if (lock_readers != 0 || lock_writer)
                    begin
                        if (waiting_writers.size() >= QUEUE_DEPTH)
                        begin
                            queue_full_drops++;
                            add_grant(id, rwl_pkg::KIND_ERROR);
                        end
                        else
                        begin
                            waiting_writers.push_back(id);
                        end
                    end
                    else
                    begin
                        lock_writer = 1'b1;
                        add_grant(id, rwl_pkg::KIND_WRITE);
                    end
                default:
                    if (!lock_writer)
                    begin
                        add_grant(id, rwl_pkg::KIND_ERROR);
                    end
                    else
                    begin
                        lock_writer = 1'b0;
                        if (waiting_readers.size() != 0)
                        begin
                            while (waiting_readers.size() != 0
                                   && step_grants.size() < rwl_pkg::RESULT_LIMIT
                                   && lock_readers < rwl_pkg::READER_MAX)
                            begin
                                lock_readers++;
                                add_grant(waiting_readers.pop_front(), rwl_pkg::KIND_READ);
                            end
                            if (step_grants.size() > widest_wakeup)
                                widest_wakeup = step_grants.size();
                        end
                        else if (waiting_writers.size() != 0)
                        begin
                            lock_writer = 1'b1;
                            add_grant(waiting_writers.pop_front(), rwl_pkg::KIND_WRITE);
                        end
                    end
            endcase
        end
        if (step_grants.size() != 0)
            step_grants[step_grants.size() - 1].last_flag = 1'b1;
    endfunction

    function automatic rwl_pkg::request_t pick_request();
        rwl_pkg::request_t r;
        r.requester_id = rwl_pkg::ID_W'($urandom_range(0, MAX_REQUESTERS - 1));
        if ($urandom_range(0, 99) < 12)
        begin
            r.command = 2'($urandom_range(0, 3));
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: r.command = rwl_pkg::CMD_START_READ;
                1: r.command = (lock_readers != 0) ? rwl_pkg::CMD_END_READ
                                                   : rwl_pkg::CMD_START_READ;
                2: r.command = rwl_pkg::CMD_START_WRITE;
                default:
                    if (lock_writer)
                        r.command = rwl_pkg::CMD_END_WRITE;
                    else if (lock_readers != 0)
                        r.command = rwl_pkg::CMD_END_READ;
                    else
                        r.command = rwl_pkg::CMD_START_WRITE;
            endcase
        end
        return r;
    endfunction

    function automatic void add_directed(rwl_pkg::command_t cmd, logic [rwl_pkg::ID_W-1:0] id,
                                         int grants, logic [rwl_pkg::ID_W-1:0] grant_id,
                                         rwl_pkg::kind_t grant_kind);
        directed_row_t row;
        row.cmd = cmd;
        row.id = id;
        row.grants = grants;
        row.grant_id = grant_id;
        row.grant_kind = grant_kind;
        directed_rows.push_back(row);
    endfunction

    task automatic issue_request(rwl_pkg::request_t req);
        int gap;
        start <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        sent_count++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic send_command(rwl_pkg::command_t cmd);
        rwl_pkg::request_t req;
        req.command = cmd;
        req.requester_id = rwl_pkg::ID_W'($urandom_range(0, MAX_REQUESTERS - 1));
        issue_request(req);
    endtask

    always @(posedge clk)
    begin : grant_monitor
        rwl_pkg::result_t want;
        if (rst_n)
        begin
            if (result_strobe)
            begin
                grants_seen++;
                if (result.grant_kind == rwl_pkg::KIND_ERROR)
                    error_grants++;
                if (expected_grants.size() == 0)
                begin
                    $error("Unexpected grant: grant_id %0d grant_kind %0d last_flag %0b",
                           result.grant_id, result.grant_kind, result.last_flag);
                    error_count++;
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (result.grant_id !== want.grant_id)
                    begin
                        $error("grant_id: expected %0d, actual %0d", want.grant_id,
                               result.grant_id);
                        error_count++;
                    end
                    if (result.grant_kind !== want.grant_kind)
                    begin
                        $error("grant_kind: expected %0d, actual %0d", want.grant_kind,
                               result.grant_kind);
                        error_count++;
                    end
                    if (result.last_flag !== want.last_flag)
                    begin
                        $error("last_flag: expected %0b, actual %0b", want.last_flag,
                               result.last_flag);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                apply_lock_request(request);
                if (typed_row)
                begin
                    if (typed_grant)
                    begin
                        want.grant_id = typed_id;
                        want.grant_kind = typed_kind;
                        want.last_flag = 1'b1;
                        expected_grants.push_back(want);
                    end
                end
                else
                begin
                    foreach (step_grants[i])
                        expected_grants.push_back(step_grants[i]);
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (result_strobe || (start && !busy))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog expired after %0d cycles with no request or grant.", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        rwl_pkg::request_t req;
        rst_n <= 1'b0;
        start <= 1'b0;
        request <= '0;
        lock_readers = 0;
        lock_writer = 1'b0;
        typed_row = 1'b0;
        burst_left = $urandom_range(1, 16);

        add_directed(rwl_pkg::CMD_END_READ,    4'd0,  1,         4'd0,  rwl_pkg::KIND_ERROR);
        add_directed(rwl_pkg::CMD_END_WRITE,   4'd15, 1,         4'd15, rwl_pkg::KIND_ERROR);
        add_directed(rwl_pkg::CMD_START_READ,  4'd0,  1,         4'd0,  rwl_pkg::KIND_READ);
        add_directed(rwl_pkg::CMD_START_READ,  4'd15, 1,         4'd15, rwl_pkg::KIND_READ);
        add_directed(rwl_pkg::CMD_START_WRITE, 4'd5,  0,         4'd0,  rwl_pkg::KIND_READ);
        add_directed(rwl_pkg::CMD_END_READ,    4'd0,  0,         4'd0,  rwl_pkg::KIND_READ);
        add_directed(rwl_pkg::CMD_END_READ,    4'd15, 1,         4'd5,  rwl_pkg::KIND_WRITE);
        add_directed(rwl_pkg::CMD_START_READ,  4'd15, 0,         4'd0,  rwl_pkg::KIND_READ);
        add_directed(rwl_pkg::CMD_START_READ,  4'd3,  0,         4'd0,  rwl_pkg::KIND_READ);
        add_directed(rwl_pkg::CMD_START_WRITE, 4'd9,  0,         4'd0,  rwl_pkg::KIND_READ);
        add_directed(rwl_pkg::CMD_START_WRITE, 4'd10, 0,         4'd0,  rwl_pkg::KIND_READ);
        add_directed(rwl_pkg::CMD_START_READ,  4'd12, 0,         4'd0,  rwl_pkg::KIND_READ);
        add_directed(rwl_pkg::CMD_END_WRITE,   4'd5,  PREDICTED, 4'd0,  rwl_pkg::KIND_READ);
        add_directed(rwl_pkg::CMD_END_READ,    4'd15, 0,         4'd0,  rwl_pkg::KIND_READ);
        add_directed(rwl_pkg::CMD_END_READ,    4'd3,  0,         4'd0,  rwl_pkg::KIND_READ);
        add_directed(rwl_pkg::CMD_END_READ,    4'd12, PREDICTED, 4'd0,  rwl_pkg::KIND_READ);
        add_directed(rwl_pkg::CMD_END_WRITE,   4'd9,  PREDICTED, 4'd0,  rwl_pkg::KIND_READ);
        add_directed(rwl_pkg::CMD_END_WRITE,   4'd10, 0,         4'd0,  rwl_pkg::KIND_READ);
        add_directed(rwl_pkg::CMD_END_READ,    4'd6,  1,         4'd6,  rwl_pkg::KIND_ERROR);
        add_directed(rwl_pkg::CMD_START_WRITE, 4'd10, 1,         4'd10, rwl_pkg::KIND_WRITE);
        add_directed(rwl_pkg::CMD_END_WRITE,   4'd10, 0,         4'd0,  rwl_pkg::KIND_READ);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            typed_row = (directed_rows[i].grants != PREDICTED);
            typed_grant = (directed_rows[i].grants == 1);
            typed_id = directed_rows[i].grant_id;
            typed_kind = directed_rows[i].grant_kind;
            req.command = directed_rows[i].cmd;
            req.requester_id = directed_rows[i].id;
            issue_request(req);
        end
        typed_row = 1'b0;

        while (sent_count < directed_rows.size() + RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    // Hold the write lock, fill the reader queue and at times overflow it, then wake every reader.
                    while (lock_readers != 0)
                        send_command(rwl_pkg::CMD_END_READ);
                    if (!lock_writer)
                        send_command(rwl_pkg::CMD_START_WRITE);
                    repeat ($urandom_range(12, 18)) send_command(rwl_pkg::CMD_START_READ);
                    send_command(rwl_pkg::CMD_END_WRITE);
                end
                1:
                begin
                    // Push the reader count up toward or to its limit and then part or all of the way back down.
                    while (lock_writer)
                        send_command(rwl_pkg::CMD_END_WRITE);
                    repeat ($urandom_range(28, 34)) send_command(rwl_pkg::CMD_START_READ);
                    repeat ($urandom_range(4, 34)) send_command(rwl_pkg::CMD_END_READ);
                end
                2:
                begin
                    repeat ($urandom_range(14, 18)) send_command(rwl_pkg::CMD_START_WRITE);
                end
                default:
                begin
                    repeat ($urandom_range(4, 16)) issue_request(pick_request());
                end
            endcase
        end
        start <= 1'b0;

        while (expected_grants.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests (%0d directed) and %0d grants, %0d of them drops.",
                 sent_count, directed_rows.size(), grants_seen, error_grants);
        $display("Full-queue drops: %0d, reader-limit drops: %0d, largest reader wakeup: %0d.",
                 queue_full_drops, reader_limit_drops, widest_wakeup);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
